[design/zwlt_pkg.sv]
`timescale 1ns / 1ps

package zwlt_pkg;

  typedef logic [1:0]  kind_t;
  typedef logic [1:0]  status_t;
  typedef logic [31:0] word_t;
  typedef logic [5:0]  pos_t;

  localparam kind_t KIND_INSERT = 2'd0;
  localparam kind_t KIND_LOOKUP = 2'd1;
  localparam kind_t KIND_REMOVE = 2'd2;

  localparam status_t ST_DONE = 2'd0;
  localparam status_t ST_DUP  = 2'd1;
  localparam status_t ST_MISS = 2'd2;
  localparam status_t ST_ZERO = 2'd3;

endpackage

[design/zwlt_req_if.sv]
`timescale 1ns / 1ps

interface zwlt_req_if;
  logic               valid;
  logic               ready;
  zwlt_pkg::kind_t    kind;
  zwlt_pkg::word_t    value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

[design/zwlt_rsp_if.sv]
`timescale 1ns / 1ps

interface zwlt_rsp_if;
  logic               valid;
  logic               ready;
  zwlt_pkg::status_t  status;
  zwlt_pkg::pos_t     position;

  modport source (output valid, output status, output position, input ready);
  modport sink   (input valid, input status, input position, output ready);
endinterface

[design/zwlt_cfg_if.sv]
`timescale 1ns / 1ps

interface zwlt_cfg_if;
  logic valid;
  logic ready;
  logic dedupe_on;

  modport source (output valid, output dedupe_on, input ready);
  modport sink   (input valid, input dedupe_on, output ready);
endinterface

[design/zero_terminated_word_list_table.sv]
`timescale 1ns / 1ps
// Channel  Modport  Word                 Accepted when
// req      sink     kind, value          req.valid && req.ready
// rsp      source   status, position     rsp.valid && rsp.ready
// cfg      sink     dedupe_on            cfg.valid && cfg.ready
//
// Lookup scans forward for the value; insert scans likewise only with dedupe_on.
// Remove scans forward, then backward; the backward pass stops at or above the hit.
// Reset starts a clearing pass; req.ready stays low meanwhile.
// req.ready is low from acceptance until the word is loaded into the rsp register.
// A stalled rsp holds one word; the next item may be accepted while it waits.

module zero_terminated_word_list_table #(
  parameter int ENTRIES = 64
) (
  input  logic         clk,
  input  logic         rst,
  zwlt_req_if.sink     req,
  zwlt_rsp_if.source   rsp,
  zwlt_cfg_if.sink     cfg
);

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int PW = $clog2(ENTRIES + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(ENTRIES - 1);
  localparam logic [PW-1:0] PTR_END  = PW'(ENTRIES);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_FWD, S_BACK, S_MOVE, S_ZAP, S_PUT, S_RESP
  } state_t;

  state_t              state;
  zwlt_pkg::kind_t     op_kind;
  zwlt_pkg::word_t     op_value;
  logic                dedupe_on;
  logic [AW-1:0]       clr_idx;
  logic [AW-1:0]       issue;
  logic                issue_on;
  logic [AW-1:0]       chk_idx;
  logic                chk_live;
  logic [AW-1:0]       hit_idx;
  logic [AW-1:0]       last_idx;
  zwlt_pkg::word_t     move_word;
  logic [PW-1:0]       wp;
  zwlt_pkg::status_t   res_status;
  logic [AW-1:0]       res_pos;

  zwlt_pkg::word_t     mem [ENTRIES];
  zwlt_pkg::word_t     rdata;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  zwlt_pkg::word_t     mem_wdata;

  logic [AW-1:0]       wp_slot;
  logic [PW-1:0]       wp_next;

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  assign wp_slot = (wp >= PTR_END) ? '0 : wp[AW-1:0];
  assign wp_next = PW'(wp_slot) + PW'(1);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_idx;
    mem_wdata = '0;
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
      end
      S_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = wp_slot;
        mem_wdata = op_value;
      end
      S_MOVE: begin
        mem_we    = 1'b1;
        mem_waddr = hit_idx;
        mem_wdata = move_word;
      end
      S_ZAP: begin
        mem_we    = 1'b1;
        mem_waddr = last_idx;
      end
      default: begin
        mem_we    = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[issue];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      dedupe_on <= 1'b1;
      wp        <= '0;
      issue_on  <= 1'b0;
      chk_live  <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        dedupe_on <= cfg.dedupe_on;
      end
      if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end

      // advance the read pipeline; scan states override below
      chk_idx  <= issue;
      chk_live <= issue_on;
      if (state == S_BACK) begin
        if (issue_on && issue != '0) begin
          issue <= issue - AW'(1);
        end else begin
          issue_on <= 1'b0;
        end
      end else begin
        if (issue_on && issue != LAST_IDX) begin
          issue <= issue + AW'(1);
        end else begin
          issue_on <= 1'b0;
        end
      end

      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + AW'(1);
          if (clr_idx == LAST_IDX) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          issue_on <= 1'b0;
          chk_live <= 1'b0;
          if (req.valid) begin
            op_kind  <= req.kind;
            op_value <= req.value;
            res_pos  <= '0;
            priority if (req.kind == zwlt_pkg::KIND_INSERT && req.value == '0) begin
              res_status <= zwlt_pkg::ST_ZERO;
              state      <= S_RESP;
            end else if (req.kind == zwlt_pkg::KIND_INSERT && !dedupe_on) begin
              state <= S_PUT;
            end else if (req.kind == zwlt_pkg::KIND_INSERT ||
                         req.kind == zwlt_pkg::KIND_LOOKUP ||
                         req.kind == zwlt_pkg::KIND_REMOVE) begin
              issue    <= '0;
              issue_on <= 1'b1;
              state    <= S_FWD;
            end else begin
              res_status <= zwlt_pkg::ST_MISS;
              state      <= S_RESP;
            end
          end
        end

        S_FWD: begin
          if (chk_live) begin
            priority if (rdata == '0 || (rdata != op_value && chk_idx == LAST_IDX)) begin
              issue_on <= 1'b0;
              chk_live <= 1'b0;
              if (op_kind == zwlt_pkg::KIND_INSERT) begin
                state <= S_PUT;
              end else begin
                res_status <= zwlt_pkg::ST_MISS;
                res_pos    <= '0;
                state      <= S_RESP;
              end
            end else if (rdata == op_value) begin
              issue_on <= 1'b0;
              chk_live <= 1'b0;
              res_pos  <= chk_idx;
              priority if (op_kind == zwlt_pkg::KIND_INSERT) begin
                res_status <= zwlt_pkg::ST_DUP;
                state      <= S_RESP;
              end else if (op_kind == zwlt_pkg::KIND_LOOKUP) begin
                res_status <= zwlt_pkg::ST_DONE;
                state      <= S_RESP;
              end else begin
                hit_idx  <= chk_idx;
                issue    <= LAST_IDX;
                issue_on <= 1'b1;
                state    <= S_BACK;
              end
            end else begin
              state <= S_FWD;
            end
          end
        end

        S_BACK: begin
          if (chk_live && (rdata != '0 || chk_idx == '0)) begin
            issue_on  <= 1'b0;
            chk_live  <= 1'b0;
            last_idx  <= chk_idx;
            move_word <= rdata;
            state     <= S_MOVE;
          end
        end

        S_MOVE: begin
          state <= S_ZAP;
        end

        S_ZAP: begin
          res_status <= zwlt_pkg::ST_DONE;
          res_pos    <= hit_idx;
          state      <= S_RESP;
        end

        S_PUT: begin
          res_status <= zwlt_pkg::ST_DONE;
          res_pos    <= wp_slot;
          wp         <= wp_next;
          state      <= S_RESP;
        end

        S_RESP: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid    <= 1'b1;
            rsp.status   <= res_status;
            rsp.position <= zwlt_pkg::pos_t'(res_pos);
            state        <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[design/zwlt_checker.sv]
`timescale 1ns / 1ps

module zwlt_checker (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input zwlt_pkg::status_t rsp_status,
  input zwlt_pkg::pos_t    rsp_position
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_position))
    else $error("stalled response changed");

  a_miss_pos: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status == zwlt_pkg::ST_MISS || rsp_status == zwlt_pkg::ST_ZERO)
      |-> rsp_position == '0)
    else $error("nonzero position on miss or zero value");

  a_busy: assert property (@(posedge clk)
    req_valid && req_ready |=> !req_ready)
    else $error("ready while item in progress");

  a_clear: assert property (@(posedge clk)
    rst |=> !req_ready)
    else $error("ready during clearing pass");

endmodule

bind zero_terminated_word_list_table zwlt_checker u_zwlt_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .rsp_status   (rsp.status),
  .rsp_position (rsp.position)
);
